// ----- rtl/vertex_declaration_token_decoder_core_macros.svh -----
// Assertion macros shared by the checker of the declaration token decoder.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef VERTEX_DECLARATION_TOKEN_DECODER_CORE_MACROS_SVH
`define VERTEX_DECLARATION_TOKEN_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define VDTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vdtd check failed");

// next-cycle implication
`define VDTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vdtd check failed");

`endif

// ----- rtl/vdtd_pkg.sv -----
// Package of the vertex declaration token decoder: codes, types, decode tables.
// No dependencies.
`timescale 1ns / 1ps

package vdtd_pkg;

	localparam int DEF_MAX_STREAMS = 16;
	localparam int DEF_TEX_SLOTS   = 8;

	// token types
	localparam logic [2:0] TT_STREAM     = 3'd1;
	localparam logic [2:0] TT_STREAMDATA = 3'd2;
	localparam logic [2:0] TT_END        = 3'd7;

	// result status codes
	localparam logic [2:0] ST_ATTR    = 3'd0;
	localparam logic [2:0] ST_STREAM  = 3'd1;
	localparam logic [2:0] ST_SKIPPED = 3'd2;
	localparam logic [2:0] ST_END     = 3'd3;
	localparam logic [2:0] ST_ERROR   = 3'd4;
	localparam logic [2:0] ST_IGNORED = 3'd5;

	// slots
	localparam logic [3:0] SLOT_POSITION = 4'd0;
	localparam logic [3:0] SLOT_NORMAL   = 4'd1;
	localparam logic [3:0] SLOT_DIFFUSE  = 4'd2;
	localparam logic [3:0] SLOT_SPECULAR = 4'd3;
	localparam logic [3:0] SLOT_TEX0     = 4'd4;
	localparam logic [3:0] SLOT_NONE     = 4'd12;

	// element codes
	localparam logic [15:0] ELEM_POSITION = 16'd0;
	localparam logic [15:0] ELEM_NORMAL   = 16'd3;
	localparam logic [15:0] ELEM_DIFFUSE  = 16'd5;
	localparam logic [15:0] ELEM_SPECULAR = 16'd6;
	localparam logic [15:0] ELEM_TEX0     = 16'd7;
	localparam logic [15:0] ELEM_MASK     = 16'hFFFF;

	localparam logic [3:0] FMT_NONE = 4'd0;

	typedef enum logic [1:0] {
		K_STREAM = 2'd0,
		K_DATA   = 2'd1,
		K_END    = 2'd2,
		K_ERROR  = 2'd3
	} kind_t;

	// one classified word, as it travels from front to back
	typedef struct packed {
		logic       first;
		logic       last;
		kind_t      kind;
		logic       stream_ok;
		logic [3:0] strm_sel;
		logic [2:0] size;
		logic [3:0] fmt;
		logic       elem_ok;
		logic [3:0] slot;
		logic       tex_hit;
		logic [3:0] tex_need;
	} cls_t;

	// dword size per data type; unknown types take nothing
	function automatic logic [2:0] dtype_size(input logic [3:0] dt);
		logic [2:0] s;
		unique case (dt)
			4'd0:    s = 3'd1;
			4'd1:    s = 3'd2;
			4'd2:    s = 3'd3;
			4'd3:    s = 3'd4;
			4'd4:    s = 3'd1;
			4'd5:    s = 3'd1;
			4'd6:    s = 3'd1;
			4'd7:    s = 3'd2;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] dtype_fmt(input logic [3:0] dt);
		return dt[3] ? FMT_NONE : dt + 4'd1;
	endfunction

endpackage

// ----- rtl/vdtd_front.sv -----
// Front end: classifies one declaration token into a cls_t word.
// Depends on vdtd_pkg.
`timescale 1ns / 1ps

module vdtd_front
	import vdtd_pkg::*;
#(
	parameter int MAX_STREAMS = DEF_MAX_STREAMS,
	parameter int TEX_SLOTS   = DEF_TEX_SLOTS
) (
	input  logic [31:0] token,
	input  logic        first,
	input  logic        last,
	output cls_t        cls
);

	logic [15:0] elem;
	logic [15:0] tex_off;
	logic        tex_hit;

	assign elem    = token[15:0] & ELEM_MASK;
	assign tex_off = elem - ELEM_TEX0;
	assign tex_hit = (elem >= ELEM_TEX0) && (tex_off < 16'(TEX_SLOTS));

	always_comb begin
		cls           = '0;
		cls.first     = first;
		cls.last      = last;
		cls.stream_ok = token[28:0] < 29'(MAX_STREAMS);
		cls.strm_sel  = token[3:0];
		cls.size      = dtype_size(token[19:16]);
		cls.fmt       = dtype_fmt(token[19:16]);
		cls.tex_hit   = tex_hit;
		cls.tex_need  = tex_off[3:0] + 4'd1;
		cls.elem_ok   = 1'b1;
		priority if (elem == ELEM_POSITION) begin
			cls.slot = SLOT_POSITION;
		end else if (elem == ELEM_NORMAL) begin
			cls.slot = SLOT_NORMAL;
		end else if (elem == ELEM_DIFFUSE) begin
			cls.slot = SLOT_DIFFUSE;
		end else if (elem == ELEM_SPECULAR) begin
			cls.slot = SLOT_SPECULAR;
		end else if (tex_hit) begin
			cls.slot = SLOT_TEX0 + tex_off[3:0];
		end else begin
			cls.slot    = SLOT_NONE;
			cls.elem_ok = 1'b0;
		end
		unique case (token[31:29])
			TT_STREAM:     cls.kind = K_STREAM;
			TT_STREAMDATA: cls.kind = K_DATA;
			TT_END:        cls.kind = K_END;
			default:       cls.kind = K_ERROR;
		endcase
	end

endmodule

// ----- rtl/vdtd_queue.sv -----
// Two-entry queue of classified words between front and back.
// Depends on vdtd_pkg.
`timescale 1ns / 1ps

module vdtd_queue
	import vdtd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cls_t head
);

	cls_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/vdtd_back.sv -----
// Back end: running declaration state and the registered result word.
// Depends on vdtd_pkg.
`timescale 1ns / 1ps

module vdtd_back
	import vdtd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cls_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [3:0] slot,
	output logic [3:0] format,
	output logic [7:0] attr_offset,
	output logic [9:0] stride_bytes,
	output logic [3:0] texcoord_count,
	output logic [3:0] bound_stream,
	output logic       done_res
);

	logic [7:0] ofs_q;
	logic [3:0] tex_q;
	logic [3:0] strm_q;
	logic       fin_q;
	logic       ovld_q;

	logic [7:0] ofs_b, ofs_n;
	logic [3:0] tex_b, tex_n;
	logic [3:0] strm_b, strm_n;
	logic       fin_b, fin_n;
	logic [8:0] sum;
	logic [2:0] st_n;
	logic [3:0] slot_n, fmt_n;

	assign q_pop = q_valid && (!ovld_q || !out_stall);

	always_comb begin
		ofs_b  = q_head.first ? 8'd0 : ofs_q;
		tex_b  = q_head.first ? 4'd0 : tex_q;
		strm_b = q_head.first ? 4'd0 : strm_q;
		fin_b  = q_head.first ? 1'b0 : fin_q;
		sum    = {1'b0, ofs_b} + {6'd0, q_head.size};
		ofs_n  = ofs_b;
		tex_n  = tex_b;
		strm_n = strm_b;
		fin_n  = fin_b;
		st_n   = ST_IGNORED;
		slot_n = SLOT_NONE;
		fmt_n  = FMT_NONE;
		if (!fin_b) begin
			unique case (q_head.kind)
				K_STREAM: begin
					st_n = ST_STREAM;
					if (q_head.stream_ok) begin
						strm_n = q_head.strm_sel;
					end
				end
				K_DATA: begin
					ofs_n = sum[8] ? 8'hFF : sum[7:0];
					if (q_head.elem_ok) begin
						st_n   = ST_ATTR;
						slot_n = q_head.slot;
						fmt_n  = q_head.fmt;
					end else begin
						st_n = ST_SKIPPED;
					end
					if (q_head.tex_hit && (q_head.tex_need > tex_b)) begin
						tex_n = q_head.tex_need;
					end
				end
				K_END: begin
					st_n  = ST_END;
					fin_n = 1'b1;
				end
				default: begin
					st_n  = ST_ERROR;
					fin_n = 1'b1;
				end
			endcase
			if (q_head.last) begin
				fin_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q  <= 8'd0;
			tex_q  <= 4'd0;
			strm_q <= 4'd0;
			fin_q  <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (q_pop) begin
				ofs_q  <= ofs_n;
				tex_q  <= tex_n;
				strm_q <= strm_n;
				fin_q  <= fin_n;
				ovld_q <= 1'b1;
			end else if (!out_stall) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status         <= st_n;
			slot           <= slot_n;
			format         <= fmt_n;
			attr_offset    <= ofs_b;
			stride_bytes   <= {ofs_n, 2'b00};
			texcoord_count <= tex_n;
			bound_stream   <= strm_n;
			done_res       <= fin_n;
		end
	end

	assign out_valid = ovld_q;

endmodule

// ----- rtl/vertex_declaration_token_decoder_core.sv -----
// Top level of the vertex declaration token decoder.
// Depends on vdtd_pkg, vdtd_front, vdtd_queue, vdtd_back.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | token, first, last
//  out     | out_valid/out_stall | status, slot, format, attr_offset,
//          |                     | stride_bytes, texcoord_count, bound_stream,
//          |                     | done_res
//
// One word per cycle sustained while out_stall stays low. An accepted word is
// written into the queue, and the back end then loads its result into the
// output register; a word is held back only while out_stall holds the result
// register and backs up the queue ahead of it.
// The back end's offset add and saturate are combinational, ahead of its registers.
// arst_n clears the running state, the queue and the output valid.
// in_stall rises only when the two-entry queue is full; out_stall holds the
// result register and, through it, backs up the queue.
`timescale 1ns / 1ps

module vertex_declaration_token_decoder_core
	import vdtd_pkg::*;
#(
	parameter int MAX_STREAMS = DEF_MAX_STREAMS,
	parameter int TEX_SLOTS   = DEF_TEX_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// input word
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] token,
	input  logic        first,
	input  logic        last,
	// result word
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  slot,
	output logic [3:0]  format,
	output logic [7:0]  attr_offset,
	output logic [9:0]  stride_bytes,
	output logic [3:0]  texcoord_count,
	output logic [3:0]  bound_stream,
	output logic        done_res
);

	cls_t cls;
	cls_t head;
	logic q_full;
	logic q_nempty;
	logic q_pop;
	logic push;

	// front: pure decode of the token, no state
	vdtd_front #(
		.MAX_STREAMS(MAX_STREAMS),
		.TEX_SLOTS  (TEX_SLOTS)
	) u_front (
		.token(token),
		.first(first),
		.last (last),
		.cls  (cls)
	);

	// stall comes from the registered fill count only
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	vdtd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(cls),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_nempty),
		.head     (head)
	);

	// back: all running state lives here, so words apply strictly in order
	vdtd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_nempty),
		.q_head        (head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.slot          (slot),
		.format        (format),
		.attr_offset   (attr_offset),
		.stride_bytes  (stride_bytes),
		.texcoord_count(texcoord_count),
		.bound_stream  (bound_stream),
		.done_res      (done_res)
	);

endmodule

// ----- rtl/vdtd_checker.sv -----
// Port-level checker for the declaration token decoder, bound to the top.
// Depends on vdtd_pkg and vertex_declaration_token_decoder_core_macros.svh.
`timescale 1ns / 1ps
`include "vertex_declaration_token_decoder_core_macros.svh"

module vdtd_checker
	import vdtd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [31:0] token,
	input logic        first,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [3:0]  slot,
	input logic [3:0]  format,
	input logic [7:0]  attr_offset,
	input logic [9:0]  stride_bytes,
	input logic [3:0]  texcoord_count,
	input logic [3:0]  bound_stream,
	input logic        done_res
);

	// a stalled input word stays offered and unchanged
	`VDTD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(token) && $stable(first) && $stable(last))
	// a stalled result stays offered
	`VDTD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// an ignored word only comes while the declaration is closed
	`VDTD_ASSERT_NOW(a_ignored_done, out_valid && (status == ST_IGNORED), done_res)
	// an end word always closes the declaration
	`VDTD_ASSERT_NOW(a_end_done, out_valid && (status == ST_END), done_res)
	// an attribute always lands in a real slot, and stride is whole dwords
	`VDTD_ASSERT_NOW(a_attr_slot, out_valid && (status == ST_ATTR), (slot != SLOT_NONE) && (stride_bytes[1:0] == 2'b00))

endmodule

bind vertex_declaration_token_decoder_core vdtd_checker u_vdtd_checker (.*);

// ----- dv/tb.sv -----
// Self-checking bench for vertex_declaration_token_decoder_core: directed token table,
// then random declarations checked word by word against an in-bench decoder.
// Depends on vdtd_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
	import vdtd_pkg::*;

	// token types the package leaves unnamed; all of them decode as errors
	localparam logic [2:0] TT_NOP  = 3'd0;
	localparam logic [2:0] TT_RSV3 = 3'd3;
	localparam logic [2:0] TT_RSV4 = 3'd4;
	localparam logic [2:0] TT_RSV5 = 3'd5;
	localparam logic [2:0] TT_RSV6 = 3'd6;

	localparam logic [3:0] DT_FLOAT4   = 4'd3;
	localparam logic [3:0] FMT_FLOAT4  = 4'd4;
	localparam int         HOLD_CYCLES = 60;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         DRAIN_WAIT  = 10;
	localparam int         MAX_REPORTS = 10;

	// one result word as the checker sees it
	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
		logic [3:0] fmt;
		logic [7:0] aoff;
		logic [9:0] stride;
		logic [3:0] texc;
		logic [3:0] strm;
		logic       done;
	} decl_res_t;

	typedef struct {
		logic [31:0] tok;
		logic        f;
		logic        l;
		bit          typed;
		decl_res_t   want;
	} stim_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [31:0] token     = '0;
	logic        first     = 1'b0;
	logic        last      = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [3:0]  slot;
	logic [3:0]  format;
	logic [7:0]  attr_offset;
	logic [9:0]  stride_bytes;
	logic [3:0]  texcoord_count;
	logic [3:0]  bound_stream;
	logic        done_res;

	vertex_declaration_token_decoder_core uut (.*);

	// decoder state mirrored by the bench
	logic [7:0] dword_off;
	logic [3:0] tex_high;
	logic [3:0] stream_bound;
	logic       decl_over;

	decl_res_t  attr_q[$];
	stim_row_t  dir_rows[$];

	int  snd_idle_pct  = 0;
	int  rcv_stall_pct = 0;
	bit  hold_req      = 1'b0;
	bit  run_done      = 1'b0;
	int  words_in      = 0;
	int  results_seen  = 0;
	int  decls         = 0;
	int  sat_hits      = 0;
	int  holds         = 0;
	int  in_stall_cyc  = 0;
	int  fails         = 0;
	int  quiet         = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Decode one accepted word, update the mirrored state, return the result word.
	function automatic decl_res_t decode_word(logic [31:0] tok, logic f, logic l);
		decl_res_t  r;
		logic [3:0] dt;
		logic [15:0] el;
		logic [2:0] sz;
		logic [3:0] fm;
		logic [8:0] sum;
		int         p;
		if (f) begin
			dword_off    = '0;
			tex_high     = '0;
			stream_bound = '0;
			decl_over    = 1'b0;
		end
		r.status = ST_IGNORED;
		r.slot   = SLOT_NONE;
		r.fmt    = FMT_NONE;
		r.aoff   = dword_off;
		if (!decl_over) begin
			case (tok[31:29])
				TT_STREAM: begin
					// out-of-range stream ids keep the old binding
					if (tok[28:0] < DEF_MAX_STREAMS)
						stream_bound = tok[3:0];
					r.status = ST_STREAM;
				end
				TT_STREAMDATA: begin
					dt = tok[19:16];
					el = tok[15:0];
					case (dt)
						4'd0, 4'd4, 4'd5, 4'd6: sz = 3'd1;
						4'd1, 4'd7:             sz = 3'd2;
						4'd2:                   sz = 3'd3;
						4'd3:                   sz = 3'd4;
						default:                sz = 3'd0;
					endcase
					fm = (dt < 4'd8) ? dt + 4'd1 : FMT_NONE;
					r.status = ST_ATTR;
					if (el == ELEM_POSITION)
						r.slot = SLOT_POSITION;
					else if (el == ELEM_NORMAL)
						r.slot = SLOT_NORMAL;
					else if (el == ELEM_DIFFUSE)
						r.slot = SLOT_DIFFUSE;
					else if (el == ELEM_SPECULAR)
						r.slot = SLOT_SPECULAR;
					else if (el >= ELEM_TEX0 && el < ELEM_TEX0 + DEF_TEX_SLOTS) begin
						p = el - ELEM_TEX0;
						r.slot = SLOT_TEX0 + 4'(p);
						if (p + 1 > tex_high)
							tex_high = 4'(p + 1);
					end else
						r.status = ST_SKIPPED;
					if (r.status == ST_ATTR)
						r.fmt = fm;
					// skipped elements still take their space
					sum = {1'b0, dword_off} + sz;
					if (sum > 9'd255) begin
						dword_off = 8'd255;
						sat_hits++;
					end else
						dword_off = sum[7:0];
				end
				TT_END: begin
					r.status  = ST_END;
					decl_over = 1'b1;
				end
				default: begin
					r.status  = ST_ERROR;
					decl_over = 1'b1;
				end
			endcase
			if (l)
				decl_over = 1'b1;
		end
		r.stride = {dword_off, 2'b00};
		r.texc   = tex_high;
		r.strm   = stream_bound;
		r.done   = decl_over;
		return r;
	endfunction

	function automatic logic [15:0] pick_elem();
		int idx;
		idx = $urandom_range(0, 11);
		case (idx)
			0:       return ELEM_POSITION;
			1:       return ELEM_NORMAL;
			2:       return ELEM_DIFFUSE;
			3:       return ELEM_SPECULAR;
			default: return ELEM_TEX0 + 16'(idx - 4);
		endcase
	endfunction

	// heavy words are mostly float4, to walk the offset into saturation
	function automatic logic [31:0] data_word(bit heavy);
		logic [31:0] t;
		int          k;
		t = $urandom();
		t[31:29] = TT_STREAMDATA;
		if (heavy)
			t[19:16] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 7)) : DT_FLOAT4;
		else if ($urandom_range(0, 9) == 0)
			t[19:16] = 4'($urandom_range(8, 15));
		else
			t[19:16] = 4'($urandom_range(0, 7));
		k = $urandom_range(0, 19);
		if (k < 15)
			t[15:0] = pick_elem();
		else if (k < 18)
			t[15:0] = 16'($urandom_range(0, 20));
		else
			t[15:0] = 16'($urandom());
		return t;
	endfunction

	function automatic logic [31:0] stream_word();
		logic [31:0] t;
		int          k;
		t = $urandom();
		t[31:29] = TT_STREAM;
		k = $urandom_range(0, 9);
		if (k < 8)
			t[28:0] = 29'($urandom_range(0, 15));
		else if (k == 8)
			t[28:0] = 29'($urandom_range(16, 31));
		return t;
	endfunction

	function automatic logic [31:0] error_word();
		logic [31:0] t;
		t = $urandom();
		case ($urandom_range(0, 4))
			0:       t[31:29] = TT_NOP;
			1:       t[31:29] = TT_RSV3;
			2:       t[31:29] = TT_RSV4;
			3:       t[31:29] = TT_RSV5;
			default: t[31:29] = TT_RSV6;
		endcase
		return t;
	endfunction

	// Offer one word until taken; the expectation is queued at the accepting edge.
	task automatic send_word(input logic [31:0] tok, input logic f, input logic l,
			input bit typed, input decl_res_t want);
		bit        took;
		decl_res_t p;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		token    <= tok;
		first    <= f;
		last     <= l;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		p = decode_word(tok, f, l);
		attr_q.push_back(typed ? want : p);
		words_in++;
	endtask

	// One declaration: first word, a body, then END, a last flag or nothing.
	task automatic send_decl();
		bit          heavy;
		int          n;
		int          k;
		int          close_mode;
		logic [31:0] t;
		heavy = ($urandom_range(0, 7) == 0);
		n = heavy ? $urandom_range(60, 90) : $urandom_range(1, 12);
		close_mode = $urandom_range(0, 19);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (heavy)
				t = (k < 5) ? stream_word() : data_word(1'b1);
			else if (k < 25)
				t = stream_word();
			else if (k < 97)
				t = data_word(1'b0);
			else
				t = error_word();
			send_word(t, i == 0, close_mode >= 12 && close_mode < 17 && i == n - 1, 1'b0, '0);
		end
		if (close_mode < 12)
			send_word({TT_END, 29'($urandom())}, 1'b0, $urandom_range(0, 3) == 0, 1'b0, '0);
		// a few stray words after the body; they are ignored only if the declaration was closed
		if ($urandom_range(0, 9) < 3)
			repeat ($urandom_range(1, 3))
				send_word($urandom(), 1'b0, 1'($urandom()), 1'b0, '0);
		decls++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (attr_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int snd, input int rcv, input int words, input bit squeeze);
		int start;
		snd_idle_pct  = snd;
		rcv_stall_pct = rcv;
		start = words_in;
		if (squeeze)
			hold_req = 1'b1;
		while (words_in - start < words) begin
			if ($urandom_range(0, 9) == 0)
				send_word($urandom(), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
					1'b0, '0);
			else
				send_decl();
		end
		drain();
	endtask

	// receiver: random stall, or a long hold-off on request
	initial begin : rcv_side
		int   hold_cnt;
		logic nxt;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_cnt = HOLD_CYCLES;
				hold_req = 1'b0;
				holds++;
			end
			if (hold_cnt > 0) begin
				nxt = 1'b1;
				hold_cnt--;
			end else
				nxt = ($urandom_range(0, 99) < rcv_stall_pct);
			@(posedge clk);
			out_stall <= nxt;
		end
	end

	// result checker; outputs are stable from the falling edge to the accepting edge
	always @(negedge clk) begin : result_check
		decl_res_t got;
		decl_res_t want;
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			got = '{status, slot, format, attr_offset, stride_bytes, texcoord_count,
				bound_stream, done_res};
			results_seen++;
			if (attr_q.size() == 0) begin
				fails++;
				if (fails <= MAX_REPORTS)
					$display("%0t: result word with nothing expected: %p", $realtime, got);
			end else begin
				want = attr_q.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= MAX_REPORTS) begin
						$display("%0t: mismatch on result %0d", $realtime, results_seen);
						$display("  exp st=%0d slot=%0d fmt=%0d off=%0d stride=%0d tex=%0d strm=%0d done=%0d",
							want.status, want.slot, want.fmt, want.aoff, want.stride,
							want.texc, want.strm, want.done);
						$display("  got st=%0d slot=%0d fmt=%0d off=%0d stride=%0d tex=%0d strm=%0d done=%0d",
							got.status, got.slot, got.fmt, got.aoff, got.stride,
							got.texc, got.strm, got.done);
					end
				end
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(negedge clk) begin
		if (arst_n && !run_done) begin
			if (in_valid && in_stall)
				in_stall_cyc++;
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
				quiet = 0;
			else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	initial begin
		dword_off    = '0;
		tex_high     = '0;
		stream_bound = '0;
		decl_over    = 1'b0;

		// directed table; typed expectations only where they are obvious
		dir_rows.push_back(stim_row_t'{{TT_STREAM, 29'd0}, 1'b1, 1'b0, 1'b1,
			decl_res_t'{ST_STREAM, SLOT_NONE, FMT_NONE, 8'd0, 10'd0, 4'd0, 4'd0, 1'b0}});
		dir_rows.push_back(stim_row_t'{{TT_STREAM, 29'd15}, 1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAM, 29'd16}, 1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAM, 29'h1FFF_FFFF}, 1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd0, ELEM_POSITION},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd1, ELEM_NORMAL},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd2, ELEM_DIFFUSE},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd3, ELEM_SPECULAR},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd4, ELEM_TEX0},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd5, ELEM_TEX0 + 16'd7},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd6, ELEM_TEX0 + 16'd8},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd7, ELEM_MASK},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd15, ELEM_POSITION},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'd0, 4'd8, 16'd1},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'h1FF, DT_FLOAT4, ELEM_TEX0 + 16'd1},
			1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{{TT_END, 29'd0}, 1'b0, 1'b0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0});
		// every error type, each opening a fresh declaration
		dir_rows.push_back(stim_row_t'{{TT_NOP, 29'd0}, 1'b1, 1'b0, 1'b1,
			decl_res_t'{ST_ERROR, SLOT_NONE, FMT_NONE, 8'd0, 10'd0, 4'd0, 4'd0, 1'b1}});
		dir_rows.push_back(stim_row_t'{{TT_RSV3, 29'h1FFF_FFFF}, 1'b1, 1'b0, 1'b1,
			decl_res_t'{ST_ERROR, SLOT_NONE, FMT_NONE, 8'd0, 10'd0, 4'd0, 4'd0, 1'b1}});
		dir_rows.push_back(stim_row_t'{{TT_RSV4, 29'd0}, 1'b1, 1'b0, 1'b1,
			decl_res_t'{ST_ERROR, SLOT_NONE, FMT_NONE, 8'd0, 10'd0, 4'd0, 4'd0, 1'b1}});
		dir_rows.push_back(stim_row_t'{{TT_RSV5, 29'h0AAA_5555}, 1'b1, 1'b0, 1'b1,
			decl_res_t'{ST_ERROR, SLOT_NONE, FMT_NONE, 8'd0, 10'd0, 4'd0, 4'd0, 1'b1}});
		dir_rows.push_back(stim_row_t'{{TT_RSV6, 29'h1555_AAAA}, 1'b1, 1'b0, 1'b1,
			decl_res_t'{ST_ERROR, SLOT_NONE, FMT_NONE, 8'd0, 10'd0, 4'd0, 4'd0, 1'b1}});
		// one-word declaration: first and last together
		dir_rows.push_back(stim_row_t'{{TT_STREAMDATA, 9'h1FF, DT_FLOAT4, ELEM_POSITION},
			1'b1, 1'b1, 1'b1,
			decl_res_t'{ST_ATTR, SLOT_POSITION, FMT_FLOAT4, 8'd0, 10'd16, 4'd0, 4'd0, 1'b1}});
		dir_rows.push_back(stim_row_t'{{TT_STREAM, 29'd3}, 1'b0, 1'b1, 1'b0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		snd_idle_pct  = 19;
		rcv_stall_pct = 56;
		foreach (dir_rows[i])
			send_word(dir_rows[i].tok, dir_rows[i].f, dir_rows[i].l, dir_rows[i].typed,
				dir_rows[i].want);
		drain();
		run_phase(19, 56, 275, 1'b0);
		// roles swapped
		run_phase(56, 19, 275, 1'b0);
		// no idling; a long receiver hold-off at the start backs up the input
		run_phase(0, 0, 275, 1'b1);

		repeat (DRAIN_WAIT) @(posedge clk);
		run_done = 1'b1;
		if (attr_q.size() != 0) begin
			$display("%0d expected results never arrived", attr_q.size());
			fails += attr_q.size();
		end
		$display("Ran %0d words in %0d declarations, %0d results checked, %0d mismatches.",
			words_in, decls, results_seen, fails);
		$display("Offset saturated %0d times; %0d hold-off(s), input stalled %0d cycles.",
			sat_hits, holds, in_stall_cyc);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
